// ===== rtl/core/mxn_pkg.sv =====
// Shared types, constants and helpers for the mutual exclusion node.
package mxn_pkg;

  localparam int MAX_NODES = 16;
  localparam int SEQ_BITS  = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int KIND_W    = 3;
  localparam int MSG_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

  localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GRANT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISH   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PEER_FIN = 3'd5;

  localparam logic [MSG_W-1:0] MSG_REQUEST  = 3'd0;
  localparam logic [MSG_W-1:0] MSG_GRANT    = 3'd1;
  localparam logic [MSG_W-1:0] MSG_LOCKED   = 3'd2;
  localparam logic [MSG_W-1:0] MSG_FINISHED = 3'd3;
  localparam logic [MSG_W-1:0] MSG_SHUTDOWN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 2'd1;

  typedef struct packed {
    logic load;  // an input item transfers this cycle
    logic emit;  // move the next pending message into the output register
  } mxn_cmd_t;

  typedef struct packed {
    logic pend_any;   // messages remain for the current item
    logic pend_last;  // the next message to go out is the final one
    logic out_free;   // output register can take a message this cycle
  } mxn_status_t;

  // Effective node count: zero counts as one, large values clip to MAX_NODES.
  function automatic logic [CNT_W-1:0] node_count(input logic [CNT_W-1:0] total);
    logic [CNT_W-1:0] n;
    if (total == '0) begin
      n = CNT_W'(1);
    end else if (total > CNT_W'(MAX_NODES)) begin
      n = CNT_W'(MAX_NODES);
    end else begin
      n = total;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/mutual_exclusion_node_unit.sv =====
// Top level of one Ricart-Agrawala mutual exclusion node.
// Each input transfer is one event (remote request, remote grant, local acquire,
// release or finish, peer finished); the node answers with zero or more message
// transfers, the final one of an event marked by out_last. The block takes one
// event at a time: the event is decoded, and its messages then leave through the output
// register at one per cycle while the output is not stalled, lowest destination first
// and a locked or shutdown message to the node itself last. An event causes at most
// the node count of messages (16), and it may cause none. The next event is taken while
// the final message still waits in the output register. Configuration writes are always
// ready and must only be issued while no event is in progress.
module mutual_exclusion_node_unit import mxn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [NODE_W-1:0]     in_source_node,
  input  logic [15:0]           in_request_seq,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MSG_W-1:0]      out_message,
  output logic [NODE_W-1:0]     out_dest_node,
  output logic [15:0]           out_seq,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mxn_cmd_t    cmd;
  mxn_status_t status;

  assign cfg_ready = 1'b1;

  mxn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mxn_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (in_kind),
    .in_source_node (in_source_node),
    .in_request_seq (in_request_seq),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_message    (out_message),
    .out_dest_node  (out_dest_node),
    .out_seq        (out_seq),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/core/mxn_ctrl.sv =====
// Controller state machine: takes one item, then steps the message emitter.
module mxn_ctrl import mxn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mxn_status_t status,
  output mxn_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.pend_any) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pend_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/mxn_dp.sv =====
// Datapath: node state, event decode, pending message set and output register.
module mxn_dp import mxn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mxn_cmd_t              cmd,
  output mxn_status_t           status,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [NODE_W-1:0]     in_source_node,
  input  logic [15:0]           in_request_seq,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MSG_W-1:0]      out_message,
  output logic [NODE_W-1:0]     out_dest_node,
  output logic [15:0]           out_seq,
  output logic                  out_last
);

  logic [NODE_W-1:0]    my_node_r, my_node_nxt;
  logic [CNT_W-1:0]     node_total_r, node_total_nxt;
  logic                 requesting_r, requesting_nxt;
  logic                 holding_r, holding_nxt;
  logic                 finished_r, finished_nxt;
  logic [SEQ_BITS-1:0]  own_seq_r, own_seq_nxt;
  logic [SEQ_BITS-1:0]  highest_seq_r, highest_seq_nxt;
  logic [CNT_W-1:0]     grants_r, grants_nxt;
  logic [MAX_NODES-1:0] deferred_r, deferred_nxt;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic [MAX_NODES-1:0] pend_mask_r, pend_mask_nxt;
  logic [MSG_W-1:0]     pend_code_r, pend_code_nxt;
  logic                 tail_r, tail_nxt;
  logic [MSG_W-1:0]     tail_code_r, tail_code_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MSG_W-1:0]     out_message_r, out_message_nxt;
  logic [NODE_W-1:0]    out_dest_r, out_dest_nxt;
  logic [15:0]          out_seq_r, out_seq_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [CNT_W-1:0]     n;
  logic [NODE_W-1:0]    self_idx;
  logic [MAX_NODES-1:0] in_range;
  logic [MAX_NODES-1:0] self_oh;
  logic [MAX_NODES-1:0] src_oh;
  logic [MAX_NODES-1:0] bcast_mask;
  logic [SEQ_BITS-1:0]  seq_in;
  logic [CNT_W-1:0]     active_dec;
  logic [CNT_W-1:0]     grants_inc;
  logic                 dead;
  logic [MAX_NODES-1:0] pick_oh;
  logic [MAX_NODES-1:0] pick_rest;
  logic [NODE_W-1:0]    pick_idx;
  logic                 taken;

  always_comb begin
    n        = node_count(node_total_r);
    self_idx = ({1'b0, my_node_r} >= n) ? NODE_W'(n - CNT_W'(1)) : my_node_r;
    for (int i = 0; i < MAX_NODES; i++) begin
      in_range[i] = (CNT_W'(i) < n);
    end
    self_oh    = MAX_NODES'(1) << self_idx;
    src_oh     = MAX_NODES'(1) << in_source_node;
    bcast_mask = in_range & ~self_oh;
    seq_in     = SEQ_BITS'(in_request_seq);
    active_dec = (active_r != '0) ? active_r - CNT_W'(1) : active_r;
    grants_inc = (grants_r != '1) ? grants_r + CNT_W'(1) : grants_r;
    dead       = finished_r && (active_r == '0);

    // Lowest pending destination goes out first.
    pick_oh   = pend_mask_r & (~pend_mask_r + MAX_NODES'(1));
    pick_rest = pend_mask_r & ~pick_oh;
    pick_idx  = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | NODE_W'(i);
      end
    end
  end

  assign taken = out_valid_r && !out_stall;

  assign status.pend_any  = (pend_mask_r != '0) || tail_r;
  assign status.pend_last = (pend_mask_r == '0) || ((pick_rest == '0) && !tail_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    my_node_nxt     = my_node_r;
    node_total_nxt  = node_total_r;
    requesting_nxt  = requesting_r;
    holding_nxt     = holding_r;
    finished_nxt    = finished_r;
    own_seq_nxt     = own_seq_r;
    highest_seq_nxt = highest_seq_r;
    grants_nxt      = grants_r;
    deferred_nxt    = deferred_r;
    active_nxt      = active_r;
    pend_mask_nxt   = pend_mask_r;
    pend_code_nxt   = pend_code_r;
    tail_nxt        = tail_r;
    tail_code_nxt   = tail_code_r;
    out_valid_nxt   = out_valid_r && !taken;
    out_message_nxt = out_message_r;
    out_dest_nxt    = out_dest_r;
    out_seq_nxt     = out_seq_r;
    out_last_nxt    = out_last_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_MY_NODE: begin
          my_node_nxt = NODE_W'(cfg_data);
        end
        CFG_NODE_TOTAL: begin
          node_total_nxt = CNT_W'(cfg_data);
          active_nxt     = node_count(CNT_W'(cfg_data));
        end
        default: begin
        end
      endcase
    end

    if (cmd.load) begin
      pend_mask_nxt = '0;
      pend_code_nxt = MSG_GRANT;
      tail_nxt      = 1'b0;
      tail_code_nxt = MSG_LOCKED;
      if (!dead) begin
        case (in_kind)
          KIND_REQUEST: begin
            if ({1'b0, in_source_node} < n) begin
              if (finished_r) begin
                pend_mask_nxt = src_oh;
              end else begin
                if (seq_in > highest_seq_r) begin
                  highest_seq_nxt = seq_in;
                end
                if (holding_r) begin
                  deferred_nxt = deferred_r | src_oh;
                end else if (!requesting_r) begin
                  pend_mask_nxt = src_oh;
                end else if ((seq_in < own_seq_r) ||
                             ((seq_in == own_seq_r) && (in_source_node < self_idx))) begin
                  pend_mask_nxt = src_oh;
                end else begin
                  deferred_nxt = deferred_r | src_oh;
                end
              end
            end
          end
          KIND_GRANT: begin
            if (requesting_r && !holding_r && !finished_r) begin
              grants_nxt = grants_inc;
              if (grants_inc == n - CNT_W'(1)) begin
                holding_nxt = 1'b1;
                tail_nxt    = 1'b1;
              end
            end
          end
          KIND_ACQUIRE: begin
            if (!requesting_r && !holding_r && !finished_r) begin
              requesting_nxt = 1'b1;
              own_seq_nxt    = (highest_seq_r == SEQ_MAX) ? SEQ_MAX
                                                          : highest_seq_r + SEQ_BITS'(1);
              grants_nxt     = '0;
              if (n == CNT_W'(1)) begin
                holding_nxt = 1'b1;
                tail_nxt    = 1'b1;
              end else begin
                pend_mask_nxt = bcast_mask;
                pend_code_nxt = MSG_REQUEST;
              end
            end
          end
          KIND_RELEASE: begin
            if (holding_r) begin
              requesting_nxt = 1'b0;
              holding_nxt    = 1'b0;
              pend_mask_nxt  = deferred_r & in_range;
              deferred_nxt   = '0;
            end
          end
          KIND_FINISH: begin
            if (!requesting_r && !holding_r && !finished_r) begin
              finished_nxt  = 1'b1;
              active_nxt    = active_dec;
              pend_mask_nxt = bcast_mask;
              pend_code_nxt = MSG_FINISHED;
              tail_nxt      = (active_dec == '0);
              tail_code_nxt = MSG_SHUTDOWN;
            end
          end
          KIND_PEER_FIN: begin
            active_nxt    = active_dec;
            tail_nxt      = finished_r && (active_dec == '0);
            tail_code_nxt = MSG_SHUTDOWN;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (pend_mask_r != '0) begin
        pend_mask_nxt   = pick_rest;
        out_message_nxt = pend_code_r;
        out_dest_nxt    = pick_idx;
        out_seq_nxt     = (pend_code_r == MSG_REQUEST) ? 16'(own_seq_r) : '0;
        out_last_nxt    = (pick_rest == '0) && !tail_r;
      end else begin
        tail_nxt        = 1'b0;
        out_message_nxt = tail_code_r;
        out_dest_nxt    = self_idx;
        out_seq_nxt     = '0;
        out_last_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_node_r     <= '0;
      node_total_r  <= CNT_W'(1);
      requesting_r  <= 1'b0;
      holding_r     <= 1'b0;
      finished_r    <= 1'b0;
      own_seq_r     <= '0;
      highest_seq_r <= '0;
      grants_r      <= '0;
      deferred_r    <= '0;
      active_r      <= CNT_W'(1);
      pend_mask_r   <= '0;
      tail_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      my_node_r     <= my_node_nxt;
      node_total_r  <= node_total_nxt;
      requesting_r  <= requesting_nxt;
      holding_r     <= holding_nxt;
      finished_r    <= finished_nxt;
      own_seq_r     <= own_seq_nxt;
      highest_seq_r <= highest_seq_nxt;
      grants_r      <= grants_nxt;
      deferred_r    <= deferred_nxt;
      active_r      <= active_nxt;
      pend_mask_r   <= pend_mask_nxt;
      tail_r        <= tail_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_code_r   <= pend_code_nxt;
    tail_code_r   <= tail_code_nxt;
    out_message_r <= out_message_nxt;
    out_dest_r    <= out_dest_nxt;
    out_seq_r     <= out_seq_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_message   = out_message_r;
  assign out_dest_node = out_dest_r;
  assign out_seq       = out_seq_r;
  assign out_last      = out_last_r;

endmodule

// ===== tb/mxn_scoreboard.sv =====
// Scoreboard for the mutual exclusion node: predicts each event's messages and checks them.
module mxn_scoreboard import mxn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [NODE_W-1:0]     in_source_node,
  input  logic [15:0]           in_request_seq,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [MSG_W-1:0]      out_message,
  input  logic [NODE_W-1:0]     out_dest_node,
  input  logic [15:0]           out_seq,
  input  logic                  out_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    msgs_owed
);

  typedef struct packed {
    logic [MSG_W-1:0]  message;
    logic [NODE_W-1:0] dest;
    logic [15:0]       seq;
    logic              last;
  } node_msg_t;

  node_msg_t owed_messages[$];

  // Configuration and protocol state of the node as the scoreboard sees it.
  logic [NODE_W-1:0] cfg_self;
  logic [CNT_W-1:0]  cfg_total;
  logic              requesting;
  logic              holding;
  logic              finished;
  logic [15:0]       own_seq;
  logic [15:0]       highest_seq;
  logic [CNT_W-1:0]  grants_seen;
  logic [15:0]       deferred;
  logic [CNT_W-1:0]  peers_left;

  function automatic logic [CNT_W-1:0] eff_nodes(input logic [CNT_W-1:0] total);
    return (total == '0) ? CNT_W'(1) :
           (total > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : total;
  endfunction

  function automatic node_msg_t make_msg(input logic [MSG_W-1:0] code,
                                         input logic [NODE_W-1:0] dest,
                                         input logic [15:0] seq);
    node_msg_t m;
    m.message = code;
    m.dest    = dest;
    m.seq     = seq;
    m.last    = 1'b0;
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MY_NODE: cfg_self = data[NODE_W-1:0];
      CFG_NODE_TOTAL: begin
        cfg_total  = data;
        peers_left = eff_nodes(data);
      end
      default: ;
    endcase
  endtask

  task automatic apply_event(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] src,
                             input logic [15:0] seq);
    logic [CNT_W-1:0]  n;
    logic [NODE_W-1:0] me;
    node_msg_t         batch[$];
    node_msg_t         m;
    n  = eff_nodes(cfg_total);
    me = (CNT_W'(cfg_self) >= n) ? NODE_W'(n - CNT_W'(1)) : cfg_self;
    // Once shut down the node stays silent until a new node count revives the peers.
    if (finished && peers_left == '0) return;
    case (kind)
      KIND_REQUEST: begin
        if (CNT_W'(src) < n) begin
          if (finished) begin
            batch.push_back(make_msg(MSG_GRANT, src, '0));
          end else begin
            if (seq > highest_seq) highest_seq = seq;
            if (holding) begin
              deferred[src] = 1'b1;
            end else if (!requesting || seq < own_seq || (seq == own_seq && src < me)) begin
              batch.push_back(make_msg(MSG_GRANT, src, '0));
            end else begin
              deferred[src] = 1'b1;
            end
          end
        end
      end
      KIND_GRANT: begin
        if (requesting && !holding && !finished) begin
          if (grants_seen != '1) grants_seen++;
          if (grants_seen == n - CNT_W'(1)) begin
            holding = 1'b1;
            batch.push_back(make_msg(MSG_LOCKED, me, '0));
          end
        end
      end
      KIND_ACQUIRE: begin
        if (!requesting && !holding && !finished) begin
          requesting  = 1'b1;
          own_seq     = (highest_seq == SEQ_MAX) ? SEQ_MAX : highest_seq + 16'd1;
          grants_seen = '0;
          if (n == CNT_W'(1)) begin
            holding = 1'b1;
            batch.push_back(make_msg(MSG_LOCKED, me, '0));
          end else begin
            for (int id = 0; id < n; id++) begin
              if (NODE_W'(id) != me) batch.push_back(make_msg(MSG_REQUEST, NODE_W'(id), own_seq));
            end
          end
        end
      end
      KIND_RELEASE: begin
        if (holding) begin
          requesting = 1'b0;
          holding    = 1'b0;
          for (int id = 0; id < n; id++) begin
            if (deferred[id]) batch.push_back(make_msg(MSG_GRANT, NODE_W'(id), '0));
          end
          deferred = '0;
        end
      end
      KIND_FINISH: begin
        if (!requesting && !holding && !finished) begin
          finished = 1'b1;
          if (peers_left != '0) peers_left--;
          for (int id = 0; id < n; id++) begin
            if (NODE_W'(id) != me) batch.push_back(make_msg(MSG_FINISHED, NODE_W'(id), '0));
          end
          if (peers_left == '0) batch.push_back(make_msg(MSG_SHUTDOWN, me, '0));
        end
      end
      KIND_PEER_FIN: begin
        if (peers_left != '0) peers_left--;
        if (finished && peers_left == '0) batch.push_back(make_msg(MSG_SHUTDOWN, me, '0));
      end
      default: ;
    endcase
    for (int i = 0; i < batch.size(); i++) begin
      m      = batch[i];
      m.last = (i == batch.size() - 1);
      owed_messages.push_back(m);
    end
  endtask

  task automatic check_message();
    node_msg_t got;
    node_msg_t want;
    got = '{out_message, out_dest_node, out_seq, out_last};
    if (owed_messages.size() == 0) begin
      report_mismatch($sformatf("unexpected message %0d dest %0d seq %h last %b",
                                got.message, got.dest, got.seq, got.last));
    end else begin
      want = owed_messages.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf({"got message %0d dest %0d seq %h last %b, ",
                                   "expected message %0d dest %0d seq %h last %b"},
                                  got.message, got.dest, got.seq, got.last,
                                  want.message, want.dest, want.seq, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_self    = '0;
      cfg_total   = CNT_W'(1);
      requesting  = 1'b0;
      holding     = 1'b0;
      finished    = 1'b0;
      own_seq     = '0;
      highest_seq = '0;
      grants_seen = '0;
      deferred    = '0;
      peers_left  = CNT_W'(1);
      owed_messages.delete();
    end else begin
      if (out_valid && !out_stall) check_message();
      if (cfg_valid && cfg_ready) write_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) apply_event(in_kind, in_source_node, in_request_seq);
    end
    msgs_owed = owed_messages.size();
  end

endmodule

// ===== tb/tb_mutual_exclusion_node_unit.sv =====
// Testbench top for the mutual exclusion node: events, configuration, output stalls, verdict.
module tb_mutual_exclusion_node_unit;
  import mxn_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 120;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [NODE_W-1:0]     in_source_node = '0;
  logic [15:0]           in_request_seq = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MSG_W-1:0]      out_message;
  logic [NODE_W-1:0]     out_dest_node;
  logic [15:0]           out_seq;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int owed_count;
  int cycle_count = 0;

  // Stimulus bookkeeping.
  int          events_sent = 0;
  int          live_nodes = 1;
  logic [15:0] seq_hint = '0;
  logic [15:0] own_guess = 16'd1;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int          hold_requests = 0;
  int          hold_served = 0;

  always #4 clk = ~clk;

  mutual_exclusion_node_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_source_node(in_source_node), .in_request_seq(in_request_seq),
    .out_valid(out_valid), .out_stall(out_stall), .out_message(out_message),
    .out_dest_node(out_dest_node), .out_seq(out_seq), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mxn_scoreboard scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_source_node(in_source_node), .in_request_seq(in_request_seq),
    .out_valid(out_valid), .out_stall(out_stall), .out_message(out_message),
    .out_dest_node(out_dest_node), .out_seq(out_seq), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatch_count), .msgs_owed(owed_count)
  );

  function automatic int node_span(input logic [CNT_W-1:0] total);
    if (total == '0) return 1;
    if (total > CNT_W'(MAX_NODES)) return MAX_NODES;
    return int'(total);
  endfunction

  function automatic logic [NODE_W-1:0] pick_src();
    if ($urandom_range(99) < 85) return NODE_W'($urandom_range(0, live_nodes - 1));
    return NODE_W'($urandom_range(0, 15));
  endfunction

  // Sequence numbers cluster around the node's own number so that ties and both orders occur.
  function automatic logic [15:0] pick_seq();
    int r;
    r = $urandom_range(11);
    if (r < 3) return own_guess - 16'd1;
    if (r < 7) return own_guess;
    if (r < 10) return own_guess + 16'd1;
    if (r == 10) return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] src,
                            input logic [15:0] seq);
    @(negedge clk);
    while (sender_gaps && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_source_node <= src;
    in_request_seq <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    if (kind == KIND_REQUEST && int'(src) < live_nodes && seq > seq_hint) seq_hint = seq;
  endtask

  // Drop valid and wait until every owed message has gone out, then wait on so that an
  // event that causes none has also finished.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODE_TOTAL) live_nodes = node_span(value);
  endtask

  // Every lock round ends with a release and the noise never acquires, so between phases
  // the node is idle and a new node count only has to wait for the owed messages.
  task automatic configure(input logic [CFG_DATA_W-1:0] me, input logic [CFG_DATA_W-1:0] total);
    quiesce();
    write_reg(CFG_MY_NODE, me);
    write_reg(CFG_NODE_TOTAL, total);
  endtask

  task automatic lock_round();
    int grants_left;
    grants_left = live_nodes - 1;
    repeat ($urandom_range(0, 1)) send_event(KIND_REQUEST, pick_src(), pick_seq());
    own_guess = (seq_hint == SEQ_MAX) ? SEQ_MAX : seq_hint + 16'd1;
    send_event(KIND_ACQUIRE, NODE_W'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    while (grants_left > 0) begin
      if ($urandom_range(2) == 0) begin
        send_event(KIND_REQUEST, pick_src(), pick_seq());
      end else begin
        send_event(KIND_GRANT, NODE_W'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
        grants_left--;
      end
    end
    repeat ($urandom_range(0, 3)) send_event(KIND_REQUEST, pick_src(), pick_seq());
    // The node is requesting or holding here, so a finish is refused.
    if ($urandom_range(9) == 0) send_event(KIND_FINISH, '0, '0);
    if ($urandom_range(19) == 0) send_event(KIND_PEER_FIN, pick_src(), '0);
    send_event(KIND_RELEASE, NODE_W'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic noise_event();
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(0, 7));
    // An acquire would leave a request open outside a lock round, and a finish would end
    // locking for the rest of the run, so both are kept out of the noise.
    if (k == KIND_FINISH) k = KIND_SPARE_HI;
    if (k == KIND_ACQUIRE) k = KIND_SPARE_LO;
    send_event(k, NODE_W'($urandom_range(0, 15)),
               ($urandom_range(3) == 0) ? 16'($urandom_range(0, 65535)) : pick_seq());
  endtask

  task automatic random_phase(input logic [CFG_DATA_W-1:0] me, input logic [CFG_DATA_W-1:0] total,
                              input int budget);
    int stop_at;
    configure(me, total);
    stop_at = events_sent + budget;
    while (events_sent < stop_at) begin
      if ($urandom_range(99) < 75) lock_round();
      else noise_event();
    end
  endtask

  // Output side: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin : drain_side
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        out_stall <= 1'b1;
        held++;
        if (held == LONG_HOLD) begin
          held = 0;
          hold_served++;
        end
      end else if (sink_stalls) begin
        out_stall <= ($urandom_range(99) < 28);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: a single node locks at once.
    send_event(KIND_ACQUIRE, '0, '0);
    send_event(KIND_RELEASE, '0, '0);

    // Four nodes, this one is node 1.
    configure(5'd1, 5'd4);
    send_event(KIND_REQUEST, 4'd2, 16'd5);
    send_event(KIND_REQUEST, 4'd15, 16'hFFFF);
    send_event(KIND_GRANT, 4'd3, 16'd0);
    send_event(KIND_RELEASE, 4'd0, 16'd0);
    send_event(KIND_SPARE_LO, 4'd0, 16'd0);
    send_event(KIND_SPARE_HI, 4'd15, 16'hFFFF);
    send_event(KIND_ACQUIRE, 4'd0, 16'd0);
    send_event(KIND_ACQUIRE, 4'd0, 16'd0);
    send_event(KIND_FINISH, 4'd0, 16'd0);
    send_event(KIND_REQUEST, 4'd0, 16'd6);   // tie, lower index wins
    send_event(KIND_REQUEST, 4'd2, 16'd6);   // tie, higher index waits
    send_event(KIND_REQUEST, 4'd3, 16'd7);
    send_event(KIND_REQUEST, 4'd3, 16'd2);
    repeat (3) send_event(KIND_GRANT, 4'd0, 16'd0);
    send_event(KIND_GRANT, 4'd2, 16'd0);
    send_event(KIND_REQUEST, 4'd0, 16'd1);
    send_event(KIND_ACQUIRE, 4'd0, 16'd0);
    send_event(KIND_FINISH, 4'd0, 16'd0);
    send_event(KIND_RELEASE, 4'd0, 16'd0);
    send_event(KIND_RELEASE, 4'd0, 16'd0);

    random_phase(5'd0, 5'd2, 10);

    // Receiver holds off while the sender keeps offering, so the block backs up.
    sender_gaps = 1'b0;
    hold_requests++;
    random_phase(5'd15, 5'd16, 20);
    sender_gaps = 1'b1;

    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_phase(5'd5, 5'd31, 15);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;

    random_phase(5'd9, 5'd0, 6);
    random_phase(5'd7, 5'd3, 10);
    random_phase(5'd2, 5'd8, 12);
    random_phase(5'd12, 5'd13, 12);
    random_phase(5'd19, 5'd1, 5);

    // Sequence saturation, peer count underflow and the local finish come last, since a
    // finished node never locks again.
    configure(5'd4, 5'd6);
    send_event(KIND_REQUEST, 4'd0, SEQ_MAX);
    send_event(KIND_ACQUIRE, 4'd0, 16'd0);
    send_event(KIND_REQUEST, 4'd5, SEQ_MAX);
    send_event(KIND_REQUEST, 4'd1, SEQ_MAX);
    repeat (5) send_event(KIND_GRANT, 4'd0, 16'd0);
    send_event(KIND_RELEASE, 4'd0, 16'd0);
    repeat (8) send_event(KIND_PEER_FIN, 4'd1, 16'd0);
    send_event(KIND_FINISH, 4'd0, 16'd0);
    send_event(KIND_REQUEST, 4'd1, 16'd3);
    send_event(KIND_PEER_FIN, 4'd1, 16'd0);

    // A new node count revives the peers: requests are granted at once until all finish.
    configure(5'd15, 5'd16);
    repeat (24) begin
      send_event(KIND_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 15)),
                 16'($urandom_range(0, 65535)));
    end
    repeat (MAX_NODES) send_event(KIND_PEER_FIN, 4'd0, 16'd0);
    send_event(KIND_REQUEST, 4'd3, 16'd9);

    configure(5'd0, 5'd0);
    send_event(KIND_REQUEST, 4'd0, 16'd1);
    send_event(KIND_REQUEST, 4'd1, 16'd1);
    send_event(KIND_PEER_FIN, 4'd0, 16'd0);

    quiesce();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== mutual_exclusion_node_unit.f =====
rtl/core/mxn_pkg.sv
rtl/core/mxn_ctrl.sv
rtl/core/mxn_dp.sv
rtl/core/mutual_exclusion_node_unit.sv
tb/mxn_scoreboard.sv
tb/tb_mutual_exclusion_node_unit.sv
